// ===== rtl/dfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared constants and types of the dshot frame encoder.
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int BURST_SLOTS = 17;
  localparam int FRAME_BITS  = 16;
  localparam int MAX_SLOTS   = 64;
  localparam int BURST_LEN   = (BURST_SLOTS < FRAME_BITS) ? FRAME_BITS :
                               (BURST_SLOTS > MAX_SLOTS) ? MAX_SLOTS : BURST_SLOTS;
  localparam int SLOT_W      = $clog2(BURST_LEN);

  localparam int THR_W    = 18;  // input sample width
  localparam int QMAG_W   = 17;  // clamped magnitude, 0..65536
  localparam int PROD_W   = 28;  // magnitude times span
  localparam int CODE_W   = 11;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [QMAG_W-1:0] FULL_SCALE   = 17'h10000;
  localparam logic [CODE_W-1:0] THR_SPAN     = 11'd1999;
  localparam logic [CODE_W-1:0] MIN_THROTTLE = 11'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_HIGH  = 2'd0,
    CFG_ZERO_HIGH = 2'd1,
    CFG_TELEM     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] zero_high;
  } tick_cfg_t;

endpackage

// ===== rtl/dfe_throttle_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_throttle_map
// Two pipeline stages: qualify and clamp the sample, then scale by the span.
// ----------------------------------------------------------------------------
module dfe_throttle_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [dfe_pkg::THR_W-1:0] throttle_q16_i,
  input  logic                            sample_valid_i,
  input  logic                            output_enabled_i,
  output logic                            prod_valid_o,
  input  logic                            prod_ready_i,
  output logic [dfe_pkg::PROD_W-1:0]      prod_o,
  output logic                            prod_zero_o
);

  logic                          s1_valid_q, s1_valid_d;
  logic [dfe_pkg::QMAG_W-1:0]    s1_mag_q, s1_mag_d;
  logic                          s1_zero_q, s1_zero_d;
  logic                          s2_valid_q, s2_valid_d;
  logic [dfe_pkg::PROD_W-1:0]    s2_prod_q, s2_prod_d;
  logic                          s2_zero_q, s2_zero_d;
  logic                          s1_ready, s2_ready;
  logic                          s1_load, s2_load;

  assign s2_ready   = !s2_valid_q || prod_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s1_load    = in_valid_i && s1_ready;
  assign s2_load    = s1_valid_q && s2_ready;

  // stage 1: zero conditions and clamp to full scale
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = in_valid_i;
    end
    s1_zero_d = !sample_valid_i || !output_enabled_i || throttle_q16_i[dfe_pkg::THR_W-1] ||
                (throttle_q16_i == '0);
    if (throttle_q16_i[dfe_pkg::QMAG_W-1:0] > dfe_pkg::FULL_SCALE) begin
      s1_mag_d = dfe_pkg::FULL_SCALE;
    end else begin
      s1_mag_d = throttle_q16_i[dfe_pkg::QMAG_W-1:0];
    end
  end

  // stage 2: one 17x11 multiply
  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_ready) begin
      s2_valid_d = s1_valid_q;
    end
    s2_prod_d = dfe_pkg::PROD_W'(s1_mag_q) * dfe_pkg::PROD_W'(dfe_pkg::THR_SPAN);
    s2_zero_d = s1_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mag_q  <= s1_mag_d;
      s1_zero_q <= s1_zero_d;
    end
    if (s2_load) begin
      s2_prod_q <= s2_prod_d;
      s2_zero_q <= s2_zero_d;
    end
  end

  assign prod_valid_o = s2_valid_q;
  assign prod_o       = s2_prod_q;
  assign prod_zero_o  = s2_zero_q;

endmodule

// ===== rtl/dfe_frame_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_frame_pack
// Third pipeline stage: throttle code, telemetry bit and checksum nibble.
// ----------------------------------------------------------------------------
module dfe_frame_pack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          prod_valid_i,
  output logic                          prod_ready_o,
  input  logic [dfe_pkg::PROD_W-1:0]    prod_i,
  input  logic                          prod_zero_i,
  input  logic                          telem_i,
  output logic                          frame_valid_o,
  input  logic                          frame_ready_i,
  output logic [dfe_pkg::FRAME_BITS-1:0] frame_o
);

  logic                           s3_valid_q, s3_valid_d;
  logic [dfe_pkg::FRAME_BITS-1:0] s3_frame_q, s3_frame_d;
  logic                           s3_ready;
  logic [dfe_pkg::CODE_W-1:0]     code;
  logic [dfe_pkg::CODE_W:0]       pkt_v;
  logic [3:0]                     crc;

  assign s3_ready     = !s3_valid_q || frame_ready_i;
  assign prod_ready_o = s3_ready;

  always_comb begin
    s3_valid_d = s3_valid_q;
    if (s3_ready) begin
      s3_valid_d = prod_valid_i;
    end
    if (prod_zero_i) begin
      code = '0;
    end else begin
      code = dfe_pkg::MIN_THROTTLE +
             prod_i[dfe_pkg::PROD_W-2 -: dfe_pkg::CODE_W];
    end
    pkt_v = {code, telem_i};
    // xor of the three nibbles of the 12-bit value
    crc        = pkt_v[3:0] ^ pkt_v[7:4] ^ pkt_v[11:8];
    s3_frame_d = {pkt_v, crc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_valid_i && s3_ready) begin
      s3_frame_q <= s3_frame_d;
    end
  end

  assign frame_valid_o = s3_valid_q;
  assign frame_o       = s3_frame_q;

endmodule

// ===== rtl/dfe_slot_ser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_slot_ser
// Expands one packet into a burst of duty slots, one slot per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module dfe_slot_ser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           frame_valid_i,
  output logic                           frame_ready_o,
  input  logic [dfe_pkg::FRAME_BITS-1:0] frame_i,
  input  dfe_pkg::tick_cfg_t             ticks_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dfe_pkg::TICK_W-1:0]     duty_ticks_o,
  output logic [dfe_pkg::FRAME_BITS-1:0] frame_word_o,
  output logic                           last_slot_o
);

  localparam logic [dfe_pkg::SLOT_W-1:0] LastSlot = dfe_pkg::SLOT_W'(dfe_pkg::BURST_LEN - 1);
  localparam logic [dfe_pkg::SLOT_W-1:0] LastBit  = dfe_pkg::SLOT_W'(dfe_pkg::FRAME_BITS - 1);

  logic                           busy_q, busy_d;
  logic [dfe_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [dfe_pkg::FRAME_BITS-1:0] frame_q;
  logic                           load, advance, is_last, in_frame, bit_val;

  assign is_last       = (slot_q == LastSlot);
  assign advance       = busy_q && out_ready_i;
  assign frame_ready_o = !busy_q || (out_ready_i && is_last);
  assign load          = frame_valid_i && frame_ready_o;

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (load) begin
      busy_d = 1'b1;
      slot_d = '0;
    end else if (advance) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        slot_d = slot_q + dfe_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end
  end

  // msb first
  assign in_frame = (slot_q <= LastBit);
  assign bit_val  = frame_q[4'hF - slot_q[3:0]];

  always_comb begin
    if (!in_frame) begin
      duty_ticks_o = '0;
    end else if (bit_val) begin
      duty_ticks_o = ticks_i.one_high;
    end else begin
      duty_ticks_o = ticks_i.zero_high;
    end
  end

  assign out_valid_o  = busy_q;
  assign frame_word_o = frame_q;
  assign last_slot_o  = is_last;

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !is_last) |=>
      (out_valid_o && slot_q == $past(slot_q) + dfe_pkg::SLOT_W'(1)))
    else $error("slot counter did not step after an accepted slot");

  a_no_early_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && frame_ready_o) |-> (out_ready_i && is_last))
    else $error("new packet taken in the middle of a burst");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_i && frame_ready_o) |=> (busy_q && slot_q == '0))
    else $error("burst did not start at slot zero");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && slot_q > LastBit) |-> (duty_ticks_o == '0))
    else $error("idle slot carries nonzero duty");

endmodule

// ===== rtl/dshot_frame_encoder_top.sv =====
`timescale 1ns / 1ps
// a burst's first slot follows its item through stages 1 to 3 and the serializer load
// throughput: one 17-slot burst per item, one slot per cycle while out_ready_i is high
// the three front stages take an item every cycle unless full and buffer while a burst drains
// reset: pipeline and serializer empty, registers one_high 60, zero_high 30, telemetry 0
// ----------------------------------------------------------------------------
// dshot_frame_encoder_top
// Throttle sample to dshot packet, expanded into a burst of timer duty slots.
// ----------------------------------------------------------------------------
module dshot_frame_encoder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dfe_pkg::TICK_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [dfe_pkg::THR_W-1:0] throttle_q16_i,
  input  logic                             sample_valid_i,
  input  logic                             output_enabled_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dfe_pkg::TICK_W-1:0]       duty_ticks_o,
  output logic [dfe_pkg::FRAME_BITS-1:0]   frame_word_o,
  output logic                             last_slot_o
);

  dfe_pkg::tick_cfg_t             ticks_q, ticks_d;
  logic                           telem_q, telem_d;
  logic                           prod_valid, prod_ready, prod_zero;
  logic [dfe_pkg::PROD_W-1:0]     prod;
  logic                           frame_valid, frame_ready;
  logic [dfe_pkg::FRAME_BITS-1:0] frame;

  always_comb begin
    ticks_d = ticks_q;
    telem_d = telem_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfe_pkg::CFG_ONE_HIGH:  ticks_d.one_high  = cfg_wdata_i;
        dfe_pkg::CFG_ZERO_HIGH: ticks_d.zero_high = cfg_wdata_i;
        dfe_pkg::CFG_TELEM:     telem_d           = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q.one_high  <= 16'd60;
      ticks_q.zero_high <= 16'd30;
      telem_q           <= 1'b0;
    end else begin
      ticks_q <= ticks_d;
      telem_q <= telem_d;
    end
  end

  dfe_throttle_map u_map (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .throttle_q16_i   (throttle_q16_i),
    .sample_valid_i   (sample_valid_i),
    .output_enabled_i (output_enabled_i),
    .prod_valid_o     (prod_valid),
    .prod_ready_i     (prod_ready),
    .prod_o           (prod),
    .prod_zero_o      (prod_zero)
  );

  dfe_frame_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .prod_valid_i  (prod_valid),
    .prod_ready_o  (prod_ready),
    .prod_i        (prod),
    .prod_zero_i   (prod_zero),
    .telem_i       (telem_q),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  dfe_slot_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .ticks_i       (ticks_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duty_ticks_o  (duty_ticks_o),
    .frame_word_o  (frame_word_o),
    .last_slot_o   (last_slot_o)
  );

endmodule
